>>> rtl/prtp_pkg.sv
`timescale 1ns / 1ps

package prtp_pkg;

   // Profile table geometry.
   localparam int TABLE_SLOTS = 8192;
   localparam int SLOT_AW     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

   // Field widths.
   localparam int ID_W    = 17;
   localparam int TICK_W  = 64;
   localparam int HIT_W   = 32;
   localparam int SLOT_W  = 14;
   localparam int COUNT_W = 64;
   localparam int ENTRY_W = TICK_W + HIT_W;

   // Request type codes.
   localparam logic REQ_MARK = 1'b0;
   localparam logic REQ_READ = 1'b1;

   // Which slot a request touches.
   localparam logic [1:0] SEL_NONE  = 2'd0;
   localparam logic [1:0] SEL_TABLE = 2'd1;
   localparam logic [1:0] SEL_OVF   = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic               accept;
      logic               update;
      logic               clear;
      logic [SLOT_AW-1:0] clear_addr;
   } cmd_type;

endpackage

>>> rtl/prtp_ram.sv
`timescale 1ns / 1ps

module prtp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/prtp_ctrl.sv
`timescale 1ns / 1ps

module prtp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output prtp_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]                   state_ff, state_in;
   logic [prtp_pkg::SLOT_AW-1:0] clear_addr_ff, clear_addr_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         accept, out_free, clear_last;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign accept     = (state_ff == ST_IDLE) && req_valid;
   assign clear_last = (clear_addr_ff == prtp_pkg::SLOT_AW'(prtp_pkg::TABLE_SLOTS - 1));

   // Next state: clear sweep after reset, then one request at a time.
   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + prtp_pkg::SLOT_AW'(1);
            if (clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result register holds until the consumer takes it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (state_ff == ST_UPDATE && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign cmd.accept     = accept;
   assign cmd.update     = (state_ff == ST_UPDATE) && out_free;
   assign cmd.clear      = (state_ff == ST_CLEAR);
   assign cmd.clear_addr = clear_addr_ff;

endmodule

>>> rtl/prtp_datapath.sv
`timescale 1ns / 1ps

module prtp_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  prtp_pkg::cmd_type                   cmd,
   input  logic                                req_type,
   input  logic signed [prtp_pkg::ID_W-1:0]    req_op_id,
   input  logic [prtp_pkg::TICK_W-1:0]         req_timestamp,
   input  logic [prtp_pkg::SLOT_W-1:0]         req_read_slot,
   output logic [prtp_pkg::TICK_W-1:0]         rsp_slot_ticks,
   output logic [prtp_pkg::HIT_W-1:0]          rsp_slot_hits,
   output logic [prtp_pkg::TICK_W-1:0]         rsp_total_ticks,
   output logic [prtp_pkg::COUNT_W-1:0]        rsp_mark_count,
   output logic signed [prtp_pkg::ID_W-1:0]    rsp_current_op
);

   // Architectural state.
   logic signed [prtp_pkg::ID_W-1:0] open_op_ff;
   logic [prtp_pkg::TICK_W-1:0]      last_stamp_ff;
   logic [prtp_pkg::COUNT_W-1:0]     marks_ff;
   logic [prtp_pkg::TICK_W-1:0]      sum_ff, sum_in;
   logic [prtp_pkg::TICK_W-1:0]      ovf_ticks_ff, ovf_ticks_in;
   logic [prtp_pkg::HIT_W-1:0]       ovf_hits_ff, ovf_hits_in;

   // Request held between lookup and update.
   logic                             is_mark_ff;
   logic [1:0]                       sel_ff, sel_in;
   logic [prtp_pkg::TICK_W-1:0]      dt_ff;

   // Result registers.
   logic [prtp_pkg::TICK_W-1:0]      out_ticks_ff, out_ticks_in;
   logic [prtp_pkg::HIT_W-1:0]       out_hits_ff, out_hits_in;
   logic [prtp_pkg::TICK_W-1:0]      out_total_ff;
   logic [prtp_pkg::COUNT_W-1:0]     out_marks_ff;
   logic signed [prtp_pkg::ID_W-1:0] out_op_ff;

   // Table memory port signals.
   logic                             ram_wr_en, ram_rd_en;
   logic [prtp_pkg::SLOT_AW-1:0]     ram_wr_addr, ram_rd_addr, upd_addr_ff;
   logic [prtp_pkg::ENTRY_W-1:0]     ram_wr_data, ram_rd_data;
   logic [prtp_pkg::TICK_W-1:0]      rd_ticks, new_ticks;
   logic [prtp_pkg::HIT_W-1:0]       rd_hits, new_hits;
   logic [prtp_pkg::ID_W-1:0]        open_mag, slot_ext;
   logic                             credit;

   assign open_mag = {1'b0, open_op_ff[prtp_pkg::ID_W-2:0]};
   assign slot_ext = prtp_pkg::ID_W'(req_read_slot);

   // Classify the request and pick the table entry to look up.
   always_comb begin
      sel_in      = prtp_pkg::SEL_NONE;
      ram_rd_addr = slot_ext[prtp_pkg::SLOT_AW-1:0];
      if (req_type == prtp_pkg::REQ_MARK) begin
         ram_rd_addr = open_mag[prtp_pkg::SLOT_AW-1:0];
         if (!open_op_ff[prtp_pkg::ID_W-1]) begin
            if (open_mag < prtp_pkg::ID_W'(prtp_pkg::TABLE_SLOTS)) begin
               sel_in = prtp_pkg::SEL_TABLE;
            end else begin
               sel_in = prtp_pkg::SEL_OVF;
            end
         end
      end else begin
         if (slot_ext < prtp_pkg::ID_W'(prtp_pkg::TABLE_SLOTS)) begin
            sel_in = prtp_pkg::SEL_TABLE;
         end else if (slot_ext == prtp_pkg::ID_W'(prtp_pkg::TABLE_SLOTS)) begin
            sel_in = prtp_pkg::SEL_OVF;
         end
      end
   end

   assign ram_rd_en = cmd.accept;

   // Accumulate: entry plus elapsed ticks for a mark, entry as is for a read.
   assign rd_ticks  = ram_rd_data[prtp_pkg::ENTRY_W-1:prtp_pkg::HIT_W];
   assign rd_hits   = ram_rd_data[prtp_pkg::HIT_W-1:0];
   assign new_ticks = rd_ticks + dt_ff;
   assign new_hits  = rd_hits + prtp_pkg::HIT_W'(1);
   assign credit    = is_mark_ff && (sel_ff != prtp_pkg::SEL_NONE);

   always_comb begin
      out_ticks_in = '0;
      out_hits_in  = '0;
      ovf_ticks_in = ovf_ticks_ff;
      ovf_hits_in  = ovf_hits_ff;
      sum_in       = credit ? (sum_ff + dt_ff) : sum_ff;
      case (sel_ff)
         prtp_pkg::SEL_TABLE: begin
            out_ticks_in = is_mark_ff ? new_ticks : rd_ticks;
            out_hits_in  = is_mark_ff ? new_hits : rd_hits;
         end
         prtp_pkg::SEL_OVF: begin
            if (is_mark_ff) begin
               ovf_ticks_in = ovf_ticks_ff + dt_ff;
               ovf_hits_in  = ovf_hits_ff + prtp_pkg::HIT_W'(1);
            end
            out_ticks_in = ovf_ticks_in;
            out_hits_in  = ovf_hits_in;
         end
         default: begin
            out_ticks_in = '0;
            out_hits_in  = '0;
         end
      endcase
   end

   // Write port: zero sweep after reset, otherwise the credited entry.
   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = upd_addr_ff;
      ram_wr_data = {new_ticks, new_hits};
      if (cmd.clear) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = cmd.clear_addr;
         ram_wr_data = '0;
      end else if (cmd.update && is_mark_ff && sel_ff == prtp_pkg::SEL_TABLE) begin
         ram_wr_en = 1'b1;
      end
   end

   prtp_ram #(
      .WIDTH (prtp_pkg::ENTRY_W),
      .DEPTH (prtp_pkg::TABLE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Control and accumulator state.
   always_ff @(posedge clock) begin
      if (reset) begin
         open_op_ff    <= '1;
         last_stamp_ff <= '0;
         marks_ff      <= '0;
         sum_ff        <= '0;
         ovf_ticks_ff  <= '0;
         ovf_hits_ff   <= '0;
      end else begin
         if (cmd.accept && req_type == prtp_pkg::REQ_MARK) begin
            open_op_ff    <= req_op_id;
            last_stamp_ff <= req_timestamp;
            marks_ff      <= marks_ff + prtp_pkg::COUNT_W'(1);
         end
         if (cmd.update) begin
            sum_ff       <= sum_in;
            ovf_ticks_ff <= ovf_ticks_in;
            ovf_hits_ff  <= ovf_hits_in;
         end
      end
   end

   // Request capture and result registers. The mark count and open op are
   // captured with the rest so a waiting response stays put while the next
   // request is taken.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         is_mark_ff  <= (req_type == prtp_pkg::REQ_MARK);
         sel_ff      <= sel_in;
         dt_ff       <= req_timestamp - last_stamp_ff;
         upd_addr_ff <= ram_rd_addr;
      end
      if (cmd.update) begin
         out_ticks_ff <= out_ticks_in;
         out_hits_ff  <= out_hits_in;
         out_total_ff <= sum_in;
         out_marks_ff <= marks_ff;
         out_op_ff    <= open_op_ff;
      end
   end

   assign rsp_slot_ticks  = out_ticks_ff;
   assign rsp_slot_hits   = out_hits_ff;
   assign rsp_total_ticks = out_total_ff;
   assign rsp_mark_count  = out_marks_ff;
   assign rsp_current_op  = out_op_ff;

endmodule

>>> rtl/per_region_tick_profiler.sv
// An accepted request moves the controller from idle to update, which registers
// the result and raises rsp_valid provided the result register is free; a stalled
// result delays it. A new request waits until the current one is done (table
// lookup, then update of the entry). Reset is synchronous and active high; then
// the block sweeps zeros through the 8192-entry slot table, one entry a cycle, with
// req_stall high till it ends. Counters, overflow slot and open op (-1) clear at once.
`timescale 1ns / 1ps

module per_region_tick_profiler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_type,
   input  logic signed [prtp_pkg::ID_W-1:0]    req_op_id,
   input  logic [prtp_pkg::TICK_W-1:0]         req_timestamp,
   input  logic [prtp_pkg::SLOT_W-1:0]         req_read_slot,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [prtp_pkg::TICK_W-1:0]         rsp_slot_ticks,
   output logic [prtp_pkg::HIT_W-1:0]          rsp_slot_hits,
   output logic [prtp_pkg::TICK_W-1:0]         rsp_total_ticks,
   output logic [prtp_pkg::COUNT_W-1:0]        rsp_mark_count,
   output logic signed [prtp_pkg::ID_W-1:0]    rsp_current_op
);

   prtp_pkg::cmd_type cmd;

   // Sequencing and handshake.
   prtp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Tables, accumulators and result registers.
   prtp_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_type        (req_type),
      .req_op_id       (req_op_id),
      .req_timestamp   (req_timestamp),
      .req_read_slot   (req_read_slot),
      .rsp_slot_ticks  (rsp_slot_ticks),
      .rsp_slot_hits   (rsp_slot_hits),
      .rsp_total_ticks (rsp_total_ticks),
      .rsp_mark_count  (rsp_mark_count),
      .rsp_current_op  (rsp_current_op)
   );

`ifndef NO_ASSERTIONS
   // A request is never taken while the table sweep is running.
   assert property (@(posedge clock) disable iff (reset) !(cmd.accept && cmd.clear))
      else $error("request accepted during table clear");

   // An accepted request blocks the next one until its update is done.
   assert property (@(posedge clock) disable iff (reset) cmd.accept |=> req_stall)
      else $error("second request accepted before update");

   // Every update leaves a valid response behind.
   assert property (@(posedge clock) disable iff (reset) cmd.update |=> rsp_valid)
      else $error("update did not produce a response");

   // Update follows only from an accepted request, never at the same time.
   assert property (@(posedge clock) disable iff (reset) cmd.update |-> !cmd.accept)
      else $error("update and accept in the same cycle");
`endif

endmodule
